FILE: hdl/imuwsi_pkg.sv
// Shared types, constants and job builders for the IMU window slicer.
// Used by imuwsi_front, imuwsi_back and imu_window_slice_interpolate_unit.
package imuwsi_pkg;

   localparam int VALUE_WIDTH     = 32;
   localparam int FRACTION_BITS   = 16;
   localparam int TIME_WIDTH      = 63;
   localparam int NUM_AXES        = 6;
   localparam int DIFF_WIDTH      = TIME_WIDTH + 1;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_START = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_END   = 2'd1;

   localparam logic [1:0] KIND_START    = 2'd0;
   localparam logic [1:0] KIND_INTERIOR = 2'd1;
   localparam logic [1:0] KIND_END      = 2'd2;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [TIME_WIDTH-1:0]         time_type;
   typedef value_type [NUM_AXES-1:0]      axes_type;

   typedef struct packed {
      time_type  sample_time;
      value_type gyro_x;
      value_type gyro_y;
      value_type gyro_z;
      value_type accel_x;
      value_type accel_y;
      value_type accel_z;
      logic      stream_end;
   } req_type;

   typedef struct packed {
      time_type   point_time;
      value_type  out_gyro_x;
      value_type  out_gyro_y;
      value_type  out_gyro_z;
      value_type  out_accel_x;
      value_type  out_accel_y;
      value_type  out_accel_z;
      logic [1:0] point_kind;
      logic       slice_last;
   } rsp_type;

   // One unit of work for the back end: a plain copy or an interpolation.
   typedef struct packed {
      logic       interp;
      logic [1:0] kind;
      logic       last;
      time_type   point_time;
      time_type   before_time;
      time_type   after_time;
      axes_type   before_vals;
      axes_type   after_vals;
   } job_type;

   typedef enum logic [1:0] {
      PH_AWAIT,
      PH_INTERIOR,
      PH_AT_END,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_PREP,
      BK_DIV,
      BK_MUL,
      BK_ADD,
      BK_OUT
   } back_state_type;

   function automatic job_type make_copy(time_type pt, axes_type v, logic [1:0] kind,
                                         logic last);
      job_type j;
      j             = '0;
      j.interp      = 1'b0;
      j.kind        = kind;
      j.last        = last;
      j.point_time  = pt;
      j.after_vals  = v;
      return j;
   endfunction

   function automatic job_type make_interp(time_type pt, time_type bt, axes_type bv,
                                           time_type at, axes_type av,
                                           logic [1:0] kind, logic last);
      job_type j;
      j             = '0;
      j.interp      = 1'b1;
      j.kind        = kind;
      j.last        = last;
      j.point_time  = pt;
      j.before_time = bt;
      j.before_vals = bv;
      j.after_time  = at;
      j.after_vals  = av;
      return j;
   endfunction

endpackage

FILE: hdl/imuwsi_front.sv
// Front end: accepts samples, tracks the window phase and queues result jobs.
// Depends on imuwsi_pkg; feeds imuwsi_back through a two-entry job queue.
module imuwsi_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  imuwsi_pkg::req_type req_data,
   input  imuwsi_pkg::time_type win_start,
   input  imuwsi_pkg::time_type win_end,
   output logic                job_valid,
   output imuwsi_pkg::job_type job_data,
   input  logic                job_pop
);
   import imuwsi_pkg::*;

   time_type  prev_time_ff, prev_time_in;
   axes_type  prev_vals_ff, prev_vals_in;
   phase_type phase_ff, phase_in;
   logic [1:0] count_ff, count_in;
   job_type   q_ff [2];
   logic [1:0] q_count_ff;
   logic      q_rd_ff;

   axes_type  cur_vals;
   time_type  t;
   time_type  start_clip;
   logic      prev_valid;
   logic      fin;
   logic      accept;
   job_type   j0, j1;
   logic [1:0] n_jobs;

   assign accept    = req_valid && req_ready;
   assign req_ready = (q_count_ff == 2'd0) && !reset;
   assign job_valid = (q_count_ff != 2'd0);
   assign job_data  = q_ff[q_rd_ff];

   // Classify the incoming word against the held sample and the window.
   always_comb begin
      cur_vals   = {req_data.accel_z, req_data.accel_y, req_data.accel_x,
                    req_data.gyro_z, req_data.gyro_y, req_data.gyro_x};
      fin        = req_data.stream_end;
      prev_valid = (count_ff != 2'd0);
      t          = (prev_valid && req_data.sample_time < prev_time_ff) ?
                   prev_time_ff : req_data.sample_time;
      start_clip = (win_start > prev_time_ff) ? win_start : prev_time_ff;
      j0         = '0;
      j1         = '0;
      n_jobs     = 2'd0;
      phase_in   = phase_ff;
      case (phase_ff)
         PH_AWAIT, PH_INTERIOR: begin
            if (phase_ff == PH_INTERIOR ||
                (prev_valid && t > win_start && t > prev_time_ff)) begin
               if (phase_ff == PH_AWAIT && win_end <= start_clip) begin
                  phase_in = PH_DONE;
               end else begin
                  if (phase_ff == PH_AWAIT) begin
                     j0 = make_interp(start_clip, prev_time_ff, prev_vals_ff, t, cur_vals,
                                      KIND_START, 1'b0);
                  end else begin
                     j0 = make_copy(prev_time_ff, prev_vals_ff, KIND_INTERIOR, 1'b0);
                  end
                  n_jobs = 2'd1;
                  // Place the new sample relative to the end time.
                  if (t > win_end) begin
                     j1       = make_interp(win_end, prev_time_ff, prev_vals_ff, t, cur_vals,
                                            KIND_END, 1'b1);
                     n_jobs   = 2'd2;
                     phase_in = PH_DONE;
                  end else if (fin) begin
                     j1     = make_copy(t, cur_vals, KIND_END, 1'b1);
                     n_jobs = 2'd2;
                  end else begin
                     phase_in = (t == win_end) ? PH_AT_END : PH_INTERIOR;
                  end
               end
            end
         end
         PH_AT_END: begin
            if (t > prev_time_ff) begin
               j0       = make_copy(prev_time_ff, prev_vals_ff, KIND_END, 1'b1);
               n_jobs   = 2'd1;
               phase_in = PH_DONE;
            end else if (fin) begin
               j0     = make_copy(t, cur_vals, KIND_END, 1'b1);
               n_jobs = 2'd1;
            end
         end
         default: begin
         end
      endcase
      // A final sample returns the stream state to its reset values.
      if (fin) begin
         prev_time_in = '0;
         prev_vals_in = '0;
         count_in     = 2'd0;
         phase_in     = PH_AWAIT;
      end else begin
         prev_time_in = t;
         prev_vals_in = cur_vals;
         count_in     = (count_ff == 2'd2) ? 2'd2 : count_ff + 2'd1;
      end
   end

   // Stream state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
         prev_vals_ff <= '0;
         phase_ff     <= PH_AWAIT;
         count_ff     <= 2'd0;
      end else if (accept) begin
         prev_time_ff <= prev_time_in;
         prev_vals_ff <= prev_vals_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
      end
   end

   // Job queue: filled only when empty, drained one job at a time.
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[0] <= j0;
         q_ff[1] <= j1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff <= 2'd0;
         q_rd_ff    <= 1'b0;
      end else if (accept) begin
         q_count_ff <= n_jobs;
         q_rd_ff    <= 1'b0;
      end else if (job_pop && job_valid) begin
         q_count_ff <= q_count_ff - 2'd1;
         q_rd_ff    <= ~q_rd_ff;
      end
   end

   a_q_count_range: assert property (@(posedge clock) disable iff (reset)
      q_count_ff != 2'd3) else $error("job queue count out of range");

   a_sample_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("sample count passed saturation");

   a_done_is_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_DONE) |=> (q_count_ff == 2'd0))
      else $error("jobs queued after the window closed");

endmodule

FILE: hdl/imuwsi_back.sv
// Back end: runs queued jobs through a bit-serial divider and a shared multiplier.
// Depends on imuwsi_pkg; takes jobs from imuwsi_front and drives the result word.
module imuwsi_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  imuwsi_pkg::job_type job_data,
   output logic                job_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output imuwsi_pkg::rsp_type rsp_data
);
   import imuwsi_pkg::*;

   localparam int STEP_WIDTH = $clog2(FRACTION_BITS);
   localparam int AXIS_WIDTH = $clog2(NUM_AXES);
   localparam int PROD_WIDTH = VALUE_WIDTH + FRACTION_BITS + 2;

   back_state_type state_ff, state_in;
   job_type   job_ff;
   logic [DIFF_WIDTH-1:0] rem_ff;
   logic [DIFF_WIDTH-1:0] span_ff;
   logic [FRACTION_BITS-1:0] frac_ff;
   logic [STEP_WIDTH-1:0] step_ff;
   logic [AXIS_WIDTH-1:0] axis_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   axes_type  res_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;

   logic [DIFF_WIDTH:0] r2, r2_sub;
   logic      ge;
   logic signed [VALUE_WIDTH:0] diff;
   logic signed [PROD_WIDTH-1:0] product;
   value_type sum;
   logic      out_load;
   logic      frac_direct;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Divider step, multiplier and accumulate for the current axis.
   always_comb begin
      r2      = {rem_ff, 1'b0};
      ge      = (r2 >= {1'b0, span_ff});
      r2_sub  = r2 - {1'b0, span_ff};
      diff    = $signed({job_ff.after_vals[axis_ff][VALUE_WIDTH-1],
                         job_ff.after_vals[axis_ff]}) -
                $signed({job_ff.before_vals[axis_ff][VALUE_WIDTH-1],
                         job_ff.before_vals[axis_ff]});
      product = PROD_WIDTH'(diff * $signed({1'b0, frac_ff}));
      sum     = job_ff.before_vals[axis_ff] + prod_ff[FRACTION_BITS +: VALUE_WIDTH];
      frac_direct = (span_ff == '0) || (rem_ff >= span_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (job_valid) state_in = job_data.interp ? BK_PREP : BK_OUT;
         BK_PREP: state_in = frac_direct ? BK_MUL : BK_DIV;
         BK_DIV:  if (step_ff == STEP_WIDTH'(FRACTION_BITS - 1)) state_in = BK_MUL;
         BK_MUL:  state_in = BK_ADD;
         BK_ADD:  state_in = (axis_ff == AXIS_WIDTH'(NUM_AXES - 1)) ? BK_OUT : BK_MUL;
         BK_OUT:  if (!rsp_valid_ff || rsp_ready) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      job_pop  = (state_ff == BK_IDLE) && job_valid;
      out_load = (state_ff == BK_OUT) && (!rsp_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Work registers.
   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff  <= job_data;
         rem_ff  <= {1'b0, job_data.point_time} - {1'b0, job_data.before_time};
         span_ff <= {1'b0, job_data.after_time} - {1'b0, job_data.before_time};
         res_ff  <= job_data.after_vals;
         step_ff <= '0;
         axis_ff <= '0;
      end
      if (state_ff == BK_PREP) begin
         frac_ff <= (span_ff != '0 && rem_ff >= span_ff) ? '1 : '0;
      end
      if (state_ff == BK_DIV) begin
         rem_ff  <= ge ? r2_sub[DIFF_WIDTH-1:0] : r2[DIFF_WIDTH-1:0];
         frac_ff <= {frac_ff[FRACTION_BITS-2:0], ge};
         step_ff <= step_ff + STEP_WIDTH'(1);
      end
      if (state_ff == BK_MUL) begin
         prod_ff <= product;
      end
      if (state_ff == BK_ADD) begin
         res_ff[axis_ff] <= sum;
         axis_ff         <= axis_ff + AXIS_WIDTH'(1);
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff.point_time  <= job_ff.point_time;
         rsp_ff.out_gyro_x  <= res_ff[0];
         rsp_ff.out_gyro_y  <= res_ff[1];
         rsp_ff.out_gyro_z  <= res_ff[2];
         rsp_ff.out_accel_x <= res_ff[3];
         rsp_ff.out_accel_y <= res_ff[4];
         rsp_ff.out_accel_z <= res_ff[5];
         rsp_ff.point_kind  <= job_ff.kind;
         rsp_ff.slice_last  <= job_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   a_div_only_interp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV || state_ff == BK_MUL) |-> job_ff.interp)
      else $error("arithmetic running on a copy job");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff) else $error("loaded result not presented");

   a_add_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_ADD) |-> ($past(state_ff) == BK_MUL))
      else $error("accumulate without a product");

endmodule

FILE: hdl/imu_window_slice_interpolate_unit.sv
// Top level of the IMU window slicer: window registers, front end and back end.
// Depends on imuwsi_pkg, imuwsi_front and imuwsi_back.
//
//   channel | ports          | direction | word
//   req     | req_valid/ready| in        | one six-axis sample with time and stream end
//   rsp     | rsp_valid/ready| out       | one slice point with kind and last flag
//   csr     | csr_valid/ready| in        | window start or end register write
//
// A sample is taken when the job queue is empty; it leaves zero, one or two jobs.
// From the accepting edge, a copy job goes straight to the back end's output state; an
// interpolation first runs the one-bit-per-cycle fraction divider and then six multiply
// and add passes. A zero span or a saturated fraction skips the divider.
// Reset is synchronous; it clears the stream state, the queue and both registers.
// A stalled result holds the back end in its output state; the front takes a new
// sample only once its job queue has drained.
module imu_window_slice_interpolate_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  imuwsi_pkg::req_type                     req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output imuwsi_pkg::rsp_type                     rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [imuwsi_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  imuwsi_pkg::time_type                    csr_data
);
   import imuwsi_pkg::*;

   time_type win_start_ff;
   time_type win_end_ff;
   logic     job_valid;
   logic     job_pop;
   job_type  job_data;

   assign csr_ready = !reset;

   // Window registers; writes to other indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= '0;
         win_end_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_START: win_start_ff <= csr_data;
            CSR_WINDOW_END:   win_end_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   imuwsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .win_start (win_start_ff),
      .win_end   (win_end_ff),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop)
   );

   imuwsi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: verif/testbench.sv
// Self-checking bench for the IMU window slicer: directed stream table, then random streams.
// Depends on imuwsi_pkg and imu_window_slice_interpolate_unit.
`timescale 1ns / 1ps

module testbench;
   import imuwsi_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   time_type csr_data;

   // Predictor copy of the window registers and the held sample.
   time_type win_start;
   time_type win_end;
   time_type held_time;
   axes_type held_vals;
   logic held_valid;
   phase_type phase;
   int seen_count;

   rsp_type slice_queue[$];
   int errors;
   int send_idle_pct;
   int recv_idle_pct;
   int long_hold;

   imu_window_slice_interpolate_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Truncating fraction of num over span, saturated when num reaches span.
   function automatic logic [FRACTION_BITS-1:0] lerp_fraction(logic [63:0] num,
                                                               logic [63:0] span);
      logic [127:0] q;
      if (span == 0) return '0;
      if (num >= span) return '1;
      q = ({64'd0, num} << FRACTION_BITS) / span;
      return q[FRACTION_BITS-1:0];
   endfunction

   // Value between before and after, rounded toward minus infinity.
   function automatic value_type lerp_value(value_type b, value_type a,
                                            logic [FRACTION_BITS-1:0] f);
      logic signed [63:0] prod;
      logic signed [63:0] diff;
      diff = 64'(a) - 64'(b);
      prod = (diff * $signed({1'b0, f})) >>> FRACTION_BITS;
      return value_type'(64'(b) + prod);
   endfunction

   function automatic axes_type sample_axes(req_type r);
      axes_type v;
      v[0] = r.gyro_x; v[1] = r.gyro_y; v[2] = r.gyro_z;
      v[3] = r.accel_x; v[4] = r.accel_y; v[5] = r.accel_z;
      return v;
   endfunction

   function automatic rsp_type make_point(time_type t, axes_type v, logic [1:0] kind,
                                          logic last);
      rsp_type p;
      p.point_time = t;
      p.out_gyro_x = v[0]; p.out_gyro_y = v[1]; p.out_gyro_z = v[2];
      p.out_accel_x = v[3]; p.out_accel_y = v[4]; p.out_accel_z = v[5];
      p.point_kind = kind;
      p.slice_last = last;
      return p;
   endfunction

   function automatic rsp_type interp_point(time_type t, time_type at, axes_type av,
                                            logic [1:0] kind, logic last);
      axes_type v;
      logic [FRACTION_BITS-1:0] f;
      f = lerp_fraction(64'(t - held_time), 64'(at - held_time));
      for (int i = 0; i < NUM_AXES; i++) v[i] = lerp_value(held_vals[i], av[i], f);
      return make_point(t, v, kind, last);
   endfunction

   // Append one expected word at the tail of the scoreboard queue.
   task automatic expect_point(rsp_type p);
      slice_queue.insert(slice_queue.size(), p);
   endtask

   // Place a new sample once the window is open behind the held sample.
   task automatic place_sample(time_type t, axes_type v, logic fin);
      if (t > win_end) begin
         expect_point(interp_point(win_end, t, v, KIND_END, 1'b1));
         phase = PH_DONE;
      end else if (fin) begin
         expect_point(make_point(t, v, KIND_END, 1'b1));
      end else begin
         phase = (t == win_end) ? PH_AT_END : PH_INTERIOR;
      end
   endtask

   task automatic predict_slice(req_type r);
      time_type t;
      time_type s;
      axes_type v;
      t = r.sample_time;
      v = sample_axes(r);
      if (held_valid && t < held_time) t = held_time;
      case (phase)
         PH_AWAIT: begin
            if (held_valid && seen_count >= 1 && t > win_start && t > held_time) begin
               s = (win_start > held_time) ? win_start : held_time;
               if (win_end <= s) phase = PH_DONE;
               else begin
                  expect_point(interp_point(s, t, v, KIND_START, 1'b0));
                  place_sample(t, v, r.stream_end);
               end
            end
         end
         PH_INTERIOR: begin
            expect_point(make_point(held_time, held_vals, KIND_INTERIOR, 1'b0));
            place_sample(t, v, r.stream_end);
         end
         PH_AT_END: begin
            if (t > held_time) begin
               expect_point(make_point(held_time, held_vals, KIND_END, 1'b1));
               phase = PH_DONE;
            end else if (r.stream_end) begin
               expect_point(make_point(t, v, KIND_END, 1'b1));
            end
         end
         default: ;
      endcase
      held_time = t;
      held_vals = v;
      held_valid = 1'b1;
      if (seen_count < 2) seen_count++;
      if (r.stream_end) begin
         held_time = '0; held_vals = '0; held_valid = 1'b0;
         phase = PH_AWAIT; seen_count = 0;
      end
   endtask

   // Every accepted word is checked against the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (slice_queue.size() == 0) begin
            $error("unexpected point at %0d", rsp_data.point_time);
            errors++;
         end else begin
            e = slice_queue.pop_front();
            if (rsp_data.point_time !== e.point_time) begin
               $error("point_time exp %0d got %0d", e.point_time, rsp_data.point_time);
               errors++;
            end
            if (rsp_data.out_gyro_x !== e.out_gyro_x) begin
               $error("out_gyro_x exp %0d got %0d", e.out_gyro_x, rsp_data.out_gyro_x);
               errors++;
            end
            if (rsp_data.out_gyro_y !== e.out_gyro_y) begin
               $error("out_gyro_y exp %0d got %0d", e.out_gyro_y, rsp_data.out_gyro_y);
               errors++;
            end
            if (rsp_data.out_gyro_z !== e.out_gyro_z) begin
               $error("out_gyro_z exp %0d got %0d", e.out_gyro_z, rsp_data.out_gyro_z);
               errors++;
            end
            if (rsp_data.out_accel_x !== e.out_accel_x) begin
               $error("out_accel_x exp %0d got %0d", e.out_accel_x, rsp_data.out_accel_x);
               errors++;
            end
            if (rsp_data.out_accel_y !== e.out_accel_y) begin
               $error("out_accel_y exp %0d got %0d", e.out_accel_y, rsp_data.out_accel_y);
               errors++;
            end
            if (rsp_data.out_accel_z !== e.out_accel_z) begin
               $error("out_accel_z exp %0d got %0d", e.out_accel_z, rsp_data.out_accel_z);
               errors++;
            end
            if (rsp_data.point_kind !== e.point_kind) begin
               $error("point_kind exp %0d got %0d", e.point_kind, rsp_data.point_kind);
               errors++;
            end
            if (rsp_data.slice_last !== e.slice_last) begin
               $error("slice_last exp %0d got %0d", e.slice_last, rsp_data.slice_last);
               errors++;
            end
         end
      end
   end

   // Receiver side: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (long_hold > 0) begin
         rsp_ready <= 1'b0;
         long_hold <= long_hold - 1;
      end else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // One register write; valid then drops and the channel rests before the task returns.
   task automatic write_window(logic [CSR_INDEX_WIDTH-1:0] idx, time_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_WINDOW_START) win_start = val;
      else if (idx == CSR_WINDOW_END) win_end = val;
      @(posedge clock);
   endtask

   // Valid stays high after a word goes in; the next word or an idle cycle replaces it.
   task automatic send_sample(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_slice(r);
   endtask

   // Wait until every expected word is out and the back end has settled.
   task automatic drain_slices();
      req_valid <= 1'b0;
      while (slice_queue.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic req_type rand_sample(time_type t, logic fin);
      req_type r;
      r.sample_time = t;
      r.gyro_x = $urandom; r.gyro_y = $urandom; r.gyro_z = $urandom;
      r.accel_x = $urandom; r.accel_y = $urandom; r.accel_z = $urandom;
      if ($urandom_range(3) == 0) begin
         r.gyro_x = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         r.accel_z = $urandom_range(1) ? 32'sh80000000 : 32'sh7fffffff;
      end
      r.stream_end = fin;
      return r;
   endfunction

   // One random stream around the current window, mostly well formed.
   task automatic random_stream(ref int count);
      int len;
      time_type t;
      time_type step;
      len = $urandom_range(12, 2);
      if ($urandom_range(9) == 0) len = 1;
      step = $urandom_range(40, 1);
      t = (win_start > step * 4) ? win_start - step * $urandom_range(4) : 0;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(9))
            0: t = t - $urandom_range(20);
            1: ;
            default: t = t + $urandom_range(step, 1);
         endcase
         send_sample(rand_sample(t, i == len - 1));
         count++;
      end
   endtask

   typedef struct {
      req_type sample;
      logic    checked;
      rsp_type point;
   } stim_row_type;

   stim_row_type directed_rows[$];

   task automatic add_row(time_type t, value_type g, logic fin);
      stim_row_type row;
      row.sample = '{t, g, -g, g, 32'sh7fffffff, 32'sh80000000, 0, fin};
      row.checked = 1'b0;
      row.point = '0;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   initial begin
      int count;
      stim_row_type row;
      errors = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_WINDOW_START;
      csr_data = '0;
      long_hold = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      win_start = '0; win_end = '0;
      held_time = '0; held_vals = '0; held_valid = 1'b0;
      phase = PH_AWAIT; seen_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset the window is empty: a two-sample stream yields nothing.
      add_row(10, 32'sh7fffffff, 1'b0);
      add_row(20, 32'sh80000000, 1'b1);
      foreach (directed_rows[i]) begin
         send_sample(directed_rows[i].sample);
      end
      directed_rows.delete();
      drain_slices();

      // Window 100..200: interpolated start, interior, repeat, backstep, end.
      write_window(CSR_WINDOW_START, 100);
      write_window(CSR_WINDOW_END, 200);
      add_row(50, 32'sh80000000, 1'b0);
      add_row(150, 32'sh7fffffff, 1'b0);
      add_row(150, 32'sh00010000, 1'b0);
      add_row(120, 32'sh00020000, 1'b0);
      add_row(180, -32'sh00010000, 1'b0);
      add_row(260, 32'sh7fffffff, 1'b1);
      // Sample exactly at the end time, repeated, then stream end on it.
      add_row(150, 0, 1'b0);
      add_row(200, 5, 1'b0);
      add_row(200, 6, 1'b1);
      // Window start and end both lie before the stream, which yields nothing.
      add_row(300, 1, 1'b0);
      add_row(300, 2, 1'b0);
      add_row(400, 3, 1'b0);
      add_row(400, 4, 1'b1);
      // One-sample stream.
      add_row(150, 9, 1'b1);
      foreach (directed_rows[i]) send_sample(directed_rows[i].sample);
      directed_rows.delete();
      drain_slices();

      // Extremes of time: stream ends at the largest timestamp.
      write_window(CSR_WINDOW_START, '1);
      write_window(CSR_WINDOW_END, '1);
      add_row(63'h7ffffffffffffff0, 1, 1'b0);
      add_row('1, 2, 1'b1);
      write_window(CSR_WINDOW_START, 0);
      foreach (directed_rows[i]) send_sample(directed_rows[i].sample);
      directed_rows.delete();
      send_sample(rand_sample(0, 1'b0));
      send_sample(rand_sample('1, 1'b0));
      send_sample(rand_sample('1, 1'b1));
      drain_slices();

      // A single typed-in check: start at zero between samples at zero and one.
      write_window(CSR_WINDOW_START, 0);
      write_window(CSR_WINDOW_END, 1);
      row.sample = '{0, 32'sh00010000, 0, 0, 0, 0, 0, 1'b0};
      send_sample(row.sample);
      row.sample = '{1, 32'sh00030000, 0, 0, 0, 0, 0, 1'b1};
      send_sample(row.sample);
      drain_slices();

      // Random part in three idling phases, with a long receiver hold-off.
      count = 0;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 88 : 0;
         recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 28 : 0;
         if (ph == 2) long_hold = 400;
         for (int k = 0; k < 110; k++) begin
            if (k % 10 == 0) begin
               drain_slices();
               write_window(CSR_WINDOW_START, $urandom_range(300));
               write_window(CSR_WINDOW_END, $urandom_range(500));
               if ($urandom_range(7) == 0)
                  write_window(CSR_WINDOW_END, '1);
            end
            random_stream(count);
            if (count >= (ph + 1) * 330) break;
         end
         drain_slices();
      end

      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
